### src/itp_pkg.sv
package itp_pkg;

    localparam int ITP_MAX_ITEMS = 64;
    localparam int CNT_W         = 6;   // smaller_before
    localparam int VAL_W         = 7;   // perm_value
    localparam int CHUNK_W       = 8;   // mask bits examined per pick cycle
    localparam int SEL_W         = 3;   // bit index within a chunk
    localparam int ZCNT_W        = 4;   // zero count of a chunk, 0..8

    typedef struct packed {
        logic              hit;     // wanted free value lies in this chunk
        logic [SEL_W-1:0]  sel;     // its bit position in the chunk
        logic [ZCNT_W-1:0] zeros;   // free values in the chunk
    } t_pick_res;

endpackage

### src/inversion_table_to_permutation_top.sv
// Channel  Dir  Handshake          Payload
// -------  ---  -----------------  ------------------------------------------
// input    in   i_valid / o_ready  i_smaller_before[5:0], i_final_item
// output   out  o_valid / i_ready  o_perm_value[6:0], o_impossible, o_run_end
//
// Loading takes one item per cycle. After the final item, each position goes
// through fetch and check, then the pick state for each 8-bit chunk of the used
// mask scanned by the shared rank-select unit (at most ceil(n/8)); each result
// then takes a value store read and the output register. Impossible runs give one
// result. o_ready is high only while loading; a stalled output holds the
// sequencer. Reset is synchronous, active low, and clears control state only.
module inversion_table_to_permutation_top #(
    parameter int MAX_ITEMS = itp_pkg::ITP_MAX_ITEMS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [itp_pkg::CNT_W-1:0] i_smaller_before,
    input  logic                      i_final_item,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [itp_pkg::VAL_W-1:0] o_perm_value,
    output logic                      o_impossible,
    output logic                      o_run_end
);
    import itp_pkg::*;

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int LW = $clog2(MAX_ITEMS + 1);
    localparam int CH = (MAX_ITEMS + CHUNK_W - 1) / CHUNK_W;
    localparam int CW = (CH > 1) ? $clog2(CH) : 1;
    localparam int MW = CH * CHUNK_W;

    typedef enum logic [6:0] {
        S_LOAD  = 7'b0000001,
        S_FETCH = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_PICK  = 7'b0001000,
        S_EREAD = 7'b0010000,
        S_EOUT  = 7'b0100000,
        S_EFAIL = 7'b1000000
    } t_state;

    t_state            r_state;
    logic [LW-1:0]     r_loaded;
    logic              r_ovf;
    logic [AW-1:0]     r_pos;
    logic [AW-1:0]     r_last;
    logic [MW-1:0]     r_used;
    logic [CNT_W-1:0]  r_rank;
    logic [CW-1:0]     r_chunk;
    logic [CNT_W-1:0]  r_cnt_rd;
    logic [VAL_W-1:0]  r_val_rd;
    logic              r_ovalid;
    logic [VAL_W-1:0]  r_oval;
    logic              r_oimp;
    logic              r_oend;

    logic [CNT_W-1:0]  count_store [MAX_ITEMS];
    logic [VAL_W-1:0]  value_store [MAX_ITEMS];

    t_pick_res         pick;
    logic              in_xfer;
    logic              store_ok;
    logic              out_free;
    logic              out_load;
    logic [VAL_W-1:0]  n_val;

    assign o_ready  = (r_state == S_LOAD);
    assign in_xfer  = i_valid && o_ready;
    assign store_ok = (r_loaded < LW'(MAX_ITEMS));
    assign out_free = !r_ovalid || i_ready;
    assign out_load = out_free && ((r_state == S_EOUT) || (r_state == S_EFAIL));
    assign n_val    = VAL_W'({r_chunk, pick.sel}) + VAL_W'(1);

    itp_pick u_pick (
        .i_used (r_used[r_chunk*CHUNK_W +: CHUNK_W]),
        .i_rank (r_rank),
        .o_res  (pick)
    );

    always_ff @(posedge i_clk) begin
        if (in_xfer && store_ok) begin
            count_store[r_loaded[AW-1:0]] <= i_smaller_before;
        end
        if (r_state == S_FETCH) begin
            r_cnt_rd <= count_store[r_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_PICK) && pick.hit) begin
            value_store[r_pos] <= n_val;
        end
        if (r_state == S_EREAD) begin
            r_val_rd <= value_store[r_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_loaded <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (in_xfer) begin
                        if (i_final_item) begin
                            r_loaded <= '0;
                            r_ovf    <= 1'b0;
                            if (r_ovf || !store_ok) begin
                                r_state <= S_EFAIL;
                            end else begin
                                r_pos   <= r_loaded[AW-1:0];
                                r_last  <= r_loaded[AW-1:0];
                                r_used  <= '0;
                                r_state <= S_FETCH;
                            end
                        end else if (store_ok) begin
                            r_loaded <= r_loaded + LW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                end
                S_FETCH: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    // free values left among 1..n equal pos+1
                    if (VAL_W'(r_cnt_rd) > VAL_W'(r_pos)) begin
                        r_state <= S_EFAIL;
                    end else begin
                        r_rank  <= r_cnt_rd;
                        r_chunk <= '0;
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    if (pick.hit) begin
                        r_used <= r_used | (MW'(1) << {r_chunk, pick.sel});
                        if (r_pos == '0) begin
                            r_state <= S_EREAD;
                        end else begin
                            r_pos   <= r_pos - AW'(1);
                            r_state <= S_FETCH;
                        end
                    end else begin
                        r_rank  <= r_rank - CNT_W'(pick.zeros);
                        r_chunk <= r_chunk + CW'(1);
                    end
                end
                S_EREAD: begin
                    r_state <= S_EOUT;
                end
                S_EOUT: begin
                    if (out_free) begin
                        r_oval   <= r_val_rd;
                        r_oimp   <= 1'b0;
                        r_oend   <= (r_pos == r_last);
                        if (r_pos == r_last) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_pos   <= r_pos + AW'(1);
                            r_state <= S_EREAD;
                        end
                    end
                end
                S_EFAIL: begin
                    if (out_free) begin
                        r_oval   <= '0;
                        r_oimp   <= 1'b1;
                        r_oend   <= 1'b1;
                        r_state  <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_valid      = r_ovalid;
    assign o_perm_value = r_oval;
    assign o_impossible = r_oimp;
    assign o_run_end    = r_oend;

`ifndef SYNTHESIS
    a_imp_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_impossible) |-> (o_perm_value == '0 && o_run_end))
        else $error("impossible result with nonzero value or no run end");

    // a held result may belong to the previous run, so check against the max length
    a_val_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_impossible) |->
            (o_perm_value != '0 && o_perm_value <= VAL_W'(MAX_ITEMS)))
        else $error("decoded value outside 1..n");

    a_chunk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK) |-> (32'(r_chunk) < CH))
        else $error("rank select ran past the used mask");

    a_run_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_final_item) |=> (r_loaded == '0 && !r_ovf))
        else $error("load count not cleared at run end");
`endif

endmodule

### src/itp_pick.sv
// Rank select over one chunk of the used mask: finds the rank-th clear bit,
// or reports how many clear bits the chunk holds so the caller can skip it.
module itp_pick (
    input  logic [itp_pkg::CHUNK_W-1:0] i_used,
    input  logic [itp_pkg::CNT_W-1:0]   i_rank,
    output itp_pkg::t_pick_res          o_res
);
    import itp_pkg::*;

    always_comb begin
        logic [ZCNT_W-1:0] seen;
        logic              found;
        logic [SEL_W-1:0]  sel;
        seen  = '0;
        found = 1'b0;
        sel   = '0;
        for (int j = 0; j < CHUNK_W; j++) begin
            if (!i_used[j]) begin
                if (!found && (CNT_W'(seen) == i_rank)) begin
                    found = 1'b1;
                    sel   = SEL_W'(j);
                end
                seen = seen + ZCNT_W'(1);
            end
        end
        o_res.hit   = found;
        o_res.sel   = sel;
        o_res.zeros = seen;
    end

endmodule

### dv/tb_inversion_table_to_permutation_top.sv
module tb_inversion_table_to_permutation_top;
    import itp_pkg::*;

    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 64;
    localparam int PHASE_COUNTS  = 80;
    localparam int NUM_PHASES    = 3;
    localparam int SND_IDLE [NUM_PHASES] = '{24, 58, 0};
    localparam int RCV_IDLE [NUM_PHASES] = '{58, 24, 0};

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             imp;
        logic             last;
    } t_perm_result;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic             fin;
        logic             known;
        logic [VAL_W-1:0] value;
        logic             imp;
    } t_dir_row;

    typedef enum int {RUN_CLEAN, RUN_BROKEN, RUN_NOISE, RUN_FULL} t_run_kind;

    // known rows are single-result runs whose answer is obvious
    localparam int NUM_DIR = 20;
    localparam t_dir_row DIR_ROWS [NUM_DIR] = '{
        '{6'd0,  1'b1, 1'b1, 7'd1, 1'b0},
        '{6'd63, 1'b1, 1'b1, 7'd0, 1'b1},
        '{6'd1,  1'b1, 1'b1, 7'd0, 1'b1},
        '{6'd0,  1'b0, 1'b0, 7'd0, 1'b0},
        '{6'd1,  1'b0, 1'b0, 7'd0, 1'b0},
        '{6'd2,  1'b1, 1'b0, 7'd0, 1'b0},
        '{6'd0,  1'b0, 1'b0, 7'd0, 1'b0},
        '{6'd0,  1'b0, 1'b0, 7'd0, 1'b0},
        '{6'd0,  1'b1, 1'b0, 7'd0, 1'b0},
        '{6'd0,  1'b0, 1'b0, 7'd0, 1'b0},
        '{6'd2,  1'b0, 1'b0, 7'd0, 1'b0},
        '{6'd1,  1'b1, 1'b0, 7'd0, 1'b0},
        '{6'd0,  1'b0, 1'b0, 7'd0, 1'b0},
        '{6'd5,  1'b1, 1'b1, 7'd0, 1'b1},
        '{6'd0,  1'b0, 1'b0, 7'd0, 1'b0},
        '{6'd1,  1'b0, 1'b0, 7'd0, 1'b0},
        '{6'd0,  1'b0, 1'b0, 7'd0, 1'b0},
        '{6'd3,  1'b1, 1'b0, 7'd0, 1'b0},
        '{6'd42, 1'b0, 1'b0, 7'd0, 1'b0},
        '{6'd21, 1'b1, 1'b1, 7'd0, 1'b1}
    };

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_ready;
    logic [CNT_W-1:0] i_smaller_before;
    logic             i_final_item;
    logic             o_valid;
    logic             i_ready = 1'b0;
    logic [VAL_W-1:0] o_perm_value;
    logic             o_impossible;
    logic             o_run_end;

    // decoder state mirror
    logic [CNT_W-1:0]         inv_counts [ITP_MAX_ITEMS];
    logic [VAL_W-1:0]         perm_vals  [ITP_MAX_ITEMS];
    logic [ITP_MAX_ITEMS-1:0] taken;
    int                       n_loaded  = 0;
    bit                       too_many  = 1'b0;

    t_perm_result perm_q [$];   // results still owed by the block
    t_perm_result fresh_q [$];  // results caused by the latest input transfer
    t_perm_result got_res;
    t_perm_result want_res;

    int snd_idle;
    int rcv_idle;
    int errors          = 0;
    int counts_sent     = 0;
    int runs_sent       = 0;
    int results_seen    = 0;
    int impossible_seen = 0;
    int quiet_cycles    = 0;

    inversion_table_to_permutation_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_smaller_before (i_smaller_before),
        .i_final_item     (i_final_item),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_perm_value     (o_perm_value),
        .o_impossible     (o_impossible),
        .o_run_end        (o_run_end)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void decode_count(input logic [CNT_W-1:0] cnt, input logic fin);
        int  n;
        int  pos;
        int  v;
        int  seen;
        int  pick;
        bit  fail;
        fresh_q.delete();
        if (n_loaded < ITP_MAX_ITEMS) begin
            inv_counts[n_loaded] = cnt;
            n_loaded++;
        end else begin
            too_many = 1'b1;
        end
        if (!fin) return;
        n        = n_loaded;
        n_loaded = 0;
        if (too_many) begin
            too_many = 1'b0;
            fresh_q.push_back('{'0, 1'b1, 1'b1});
            return;
        end
        taken = '0;
        fail  = 1'b0;
        // last position first: take the (count+1)-th smallest free value
        for (pos = n - 1; pos >= 0 && !fail; pos--) begin
            seen = 0;
            pick = 0;
            for (v = 0; v < n; v++) begin
                if (!taken[v]) begin
                    if (pick == 0 && seen == int'(inv_counts[pos])) begin
                        pick     = v + 1;
                        taken[v] = 1'b1;
                    end
                    seen++;
                end
            end
            if (pick == 0) fail = 1'b1;
            else perm_vals[pos] = VAL_W'(pick);
        end
        if (fail) begin
            fresh_q.push_back('{'0, 1'b1, 1'b1});
            return;
        end
        for (pos = 0; pos < n; pos++)
            fresh_q.push_back('{perm_vals[pos], 1'b0, (pos == n - 1)});
    endfunction

    task automatic push_count(input logic [CNT_W-1:0] cnt, input logic fin,
                              input bit known = 1'b0,
                              input logic [VAL_W-1:0] kval = '0, input logic kimp = 1'b0);
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid          = 1'b1;
        i_smaller_before = cnt;
        i_final_item     = fin;
        do @(posedge i_clk); while (!o_ready);
        decode_count(cnt, fin);
        counts_sent++;
        if (fin) runs_sent++;
        if (known) perm_q.push_back('{kval, kimp, 1'b1});
        else foreach (fresh_q[k]) perm_q.push_back(fresh_q[k]);
    endtask

    task automatic send_run(input int len, input t_run_kind kind);
        int               bad_pos;
        int               top;
        logic [CNT_W-1:0] cnt;
        bad_pos = $urandom_range(len - 1);
        for (int i = 0; i < len; i++) begin
            top = (i > 63) ? 63 : i;
            cnt = CNT_W'($urandom_range(top));
            case (kind)
                RUN_BROKEN: begin
                    if (i == bad_pos && i < 63) cnt = CNT_W'($urandom_range(63, i + 1));
                end
                RUN_NOISE: begin
                    cnt = CNT_W'($urandom_range(63));
                end
                RUN_FULL: begin
                    if (i == 63) cnt = 6'd63;
                end
                default: ;
            endcase
            push_count(cnt, i == len - 1);
        end
    endtask

    // hold the input side off until the block has caught up
    task automatic drain_results();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (perm_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic note_error(input string what, input t_perm_result want,
                              input t_perm_result got);
        errors++;
        if (errors <= 10)
            $display("%0t: %s: expected value=%0d imp=%b end=%b, got value=%0d imp=%b end=%b",
                     $realtime, what, want.value, want.imp, want.last,
                     got.value, got.imp, got.last);
    endtask

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rcv_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            got_res = '{o_perm_value, o_impossible, o_run_end};
            results_seen++;
            if (o_impossible) impossible_seen++;
            if (perm_q.size() == 0) begin
                note_error("unexpected result", '0, got_res);
            end else begin
                want_res = perm_q.pop_front();
                if (got_res.value !== want_res.value || got_res.imp !== want_res.imp ||
                    got_res.last !== want_res.last)
                    note_error("result mismatch", want_res, got_res);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer in %0d cycles, %0d results pending",
                     STALL_LIMIT, perm_q.size());
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int        phase_start;
        int        len;
        int        pick;
        t_run_kind kind;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_smaller_before = '0;
        i_final_item     = 1'b0;
        snd_idle         = SND_IDLE[0];
        rcv_idle         = RCV_IDLE[0];
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < NUM_DIR; r++)
            push_count(DIR_ROWS[r].cnt, DIR_ROWS[r].fin, DIR_ROWS[r].known,
                       DIR_ROWS[r].value, DIR_ROWS[r].imp);
        drain_results();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            snd_idle    = SND_IDLE[ph];
            rcv_idle    = RCV_IDLE[ph];
            phase_start = counts_sent;
            if (ph == 0) send_run(64, RUN_FULL);
            if (ph == 1) send_run($urandom_range(68, 65), RUN_CLEAN);
            while (counts_sent - phase_start < PHASE_COUNTS) begin
                len  = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
                pick = $urandom_range(99);
                kind = (pick < 70) ? RUN_CLEAN : (pick < 88) ? RUN_BROKEN : RUN_NOISE;
                send_run(len, kind);
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d counts in %0d runs: directed, full-length, overflow, broken, noise.",
                 counts_sent, runs_sent);
        $display("Checked %0d results (%0d impossible), %0d mismatches.",
                 results_seen, impossible_seen, errors);
        if (errors == 0 && perm_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
